// File: design/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants for the frame deframer: parser phases, result
// kinds, error codes, opcodes and the request word passed front to back.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4,
    PH_DROP = 3'd5
  } wsfd_phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } wsfd_kind_e;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_RSV      = 4'd1,
    ERR_UNMASKED = 4'd2,
    ERR_FRAG     = 4'd3,
    ERR_OPCODE   = 4'd4,
    ERR_CTRL_LEN = 4'd5,
    ERR_LEN64    = 4'd6,
    ERR_NONMIN   = 4'd7,
    ERR_CAP      = 4'd8
  } wsfd_err_e;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [7:0] RSV_MASK     = 8'h70;
  localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;
  localparam logic [15:0] LEN_MIN16   = 16'd126;
  localparam logic [15:0] CAP_RESET   = 16'd4096;

  // Classified request from the parser: raw byte and its key byte are
  // combined in the back end.
  typedef struct packed {
    logic [7:0]  raw;
    logic [7:0]  key;
    logic [3:0]  opcode;
    wsfd_kind_e  kind;
    wsfd_err_e   err;
    logic [15:0] len;
    logic        last;
  } wsfd_req_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [3:0]  opcode;
    wsfd_kind_e  kind;
    wsfd_err_e   err;
    logic [15:0] len;
    logic        last;
  } wsfd_res_t;

endpackage

// File: design/wsfd_parser.sv
// ----------------------------------------------------------------------------
// wsfd_parser
// Front end: walks the frame header byte by byte, checks it, captures the
// mask key and classifies every accepted byte into at most one request.
// ----------------------------------------------------------------------------
module wsfd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                restart_i,
  input  logic [15:0]         max_payload_i,
  output logic                req_valid_o,
  output wsfd_pkg::wsfd_req_t req_o
);

  wsfd_pkg::wsfd_phase_e phase_q, phase_d, phase_cur;
  logic [3:0]  opcode_q, opcode_d;
  logic [15:0] len_q, len_d;
  logic [15:0] idx_q, idx_d;
  logic [7:0]  key_q [4];
  logic [7:0]  key_d [4];
  logic [1:0]  hcnt_q, hcnt_d;

  logic               fail;
  wsfd_pkg::wsfd_err_e fail_code;
  logic [6:0]         l7;
  logic [15:0]        ext_len;
  logic [16:0]        idx_inc;
  logic               fin;
  logic               op_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsfd_pkg::PH_HDR0;
      opcode_q <= '0;
      len_q    <= '0;
      idx_q    <= '0;
      hcnt_q   <= '0;
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
    end else if (accept_i) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      hcnt_q   <= hcnt_d;
      key_q    <= key_d;
    end
  end

  assign l7      = in_byte_i[6:0];
  assign ext_len = {len_q[7:0], in_byte_i};
  assign idx_inc = {1'b0, idx_q} + 17'd1;
  assign fin     = (idx_inc >= {1'b0, len_q});
  assign op_ok   = (opcode_q == wsfd_pkg::OP_TEXT)  || (opcode_q == wsfd_pkg::OP_CLOSE) ||
                   (opcode_q == wsfd_pkg::OP_PING)  || (opcode_q == wsfd_pkg::OP_PONG);

  always_comb begin
    phase_cur = restart_i ? wsfd_pkg::PH_HDR0 : phase_q;
    phase_d   = phase_cur;
    opcode_d  = opcode_q;
    len_d     = len_q;
    idx_d     = idx_q;
    hcnt_d    = hcnt_q;
    key_d     = key_q;
    fail      = 1'b0;
    fail_code = wsfd_pkg::ERR_NONE;
    req_valid_o = 1'b0;
    req_o       = '0;

    case (phase_cur)
      wsfd_pkg::PH_HDR0: begin
        if ((in_byte_i & wsfd_pkg::RSV_MASK) != 8'd0) begin
          fail      = 1'b1;
          fail_code = wsfd_pkg::ERR_RSV;
        end else begin
          // FIN clear folds into the continuation opcode
          opcode_d = in_byte_i[7] ? in_byte_i[3:0] : wsfd_pkg::OP_CONT;
          len_d    = '0;
          idx_d    = '0;
          hcnt_d   = '0;
          for (int i = 0; i < 4; i++) begin
            key_d[i] = '0;
          end
          phase_d  = wsfd_pkg::PH_HDR1;
        end
      end
      wsfd_pkg::PH_HDR1: begin
        if (!in_byte_i[7]) begin
          fail = 1'b1; fail_code = wsfd_pkg::ERR_UNMASKED;
        end else if (opcode_q == wsfd_pkg::OP_CONT) begin
          fail = 1'b1; fail_code = wsfd_pkg::ERR_FRAG;
        end else if (!op_ok) begin
          fail = 1'b1; fail_code = wsfd_pkg::ERR_OPCODE;
        end else if (opcode_q[3] && (l7 > wsfd_pkg::LEN_CTRL_MAX)) begin
          fail = 1'b1; fail_code = wsfd_pkg::ERR_CTRL_LEN;
        end else if (l7 == wsfd_pkg::LEN_EXT64) begin
          fail = 1'b1; fail_code = wsfd_pkg::ERR_LEN64;
        end else begin
          hcnt_d = '0;
          if (l7 == wsfd_pkg::LEN_EXT16) begin
            phase_d = wsfd_pkg::PH_EXT;
          end else if ({9'd0, l7} > max_payload_i) begin
            fail = 1'b1; fail_code = wsfd_pkg::ERR_CAP;
          end else begin
            len_d   = {9'd0, l7};
            phase_d = wsfd_pkg::PH_MASK;
          end
        end
      end
      wsfd_pkg::PH_EXT: begin
        len_d = ext_len;
        if (hcnt_q == 2'd0) begin
          hcnt_d = 2'd1;
        end else begin
          hcnt_d = 2'd0;
          if (ext_len < wsfd_pkg::LEN_MIN16) begin
            fail = 1'b1; fail_code = wsfd_pkg::ERR_NONMIN;
          end else if (ext_len > max_payload_i) begin
            fail = 1'b1; fail_code = wsfd_pkg::ERR_CAP;
          end else begin
            phase_d = wsfd_pkg::PH_MASK;
          end
        end
      end
      wsfd_pkg::PH_MASK: begin
        key_d[hcnt_q] = in_byte_i;
        if (hcnt_q != 2'd3) begin
          hcnt_d = hcnt_q + 2'd1;
        end else begin
          hcnt_d = '0;
          idx_d  = '0;
          if (len_q == 16'd0) begin
            // empty payload: one completion request
            phase_d     = wsfd_pkg::PH_HDR0;
            req_valid_o = 1'b1;
            req_o.opcode = opcode_q;
            req_o.kind   = wsfd_pkg::KIND_DONE;
            req_o.last   = 1'b1;
          end else begin
            phase_d = wsfd_pkg::PH_DATA;
          end
        end
      end
      wsfd_pkg::PH_DATA: begin
        req_valid_o  = 1'b1;
        req_o.raw    = in_byte_i;
        req_o.key    = key_q[idx_q[1:0]];
        req_o.opcode = opcode_q;
        req_o.kind   = wsfd_pkg::KIND_DATA;
        req_o.len    = len_q;
        req_o.last   = fin;
        idx_d        = idx_inc[15:0];
        if (fin) begin
          phase_d = wsfd_pkg::PH_HDR0;
        end
      end
      default: begin
        // dropping until restart
      end
    endcase

    if (fail) begin
      phase_d     = wsfd_pkg::PH_DROP;
      req_valid_o = 1'b1;
      req_o       = '0;
      req_o.kind  = wsfd_pkg::KIND_ERROR;
      req_o.err   = fail_code;
      req_o.last  = 1'b1;
    end

    if (!accept_i) begin
      req_valid_o = 1'b0;
    end
  end

endmodule

// File: design/wsfd_fifo.sv
// ----------------------------------------------------------------------------
// wsfd_fifo
// Short request queue between parser and output stage.
// ----------------------------------------------------------------------------
module wsfd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  wsfd_pkg::wsfd_req_t wdata_i,
  input  logic                rd_i,
  output wsfd_pkg::wsfd_req_t rdata_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  wsfd_pkg::wsfd_req_t mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= bump(wptr_q);
      if (rd_i) rptr_q <= bump(rptr_q);
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

// File: design/wsfd_unmask.sv
// ----------------------------------------------------------------------------
// wsfd_unmask
// Back end: pulls requests from the queue, unmasks payload bytes and holds
// the result in the output register until it is popped.
// ----------------------------------------------------------------------------
module wsfd_unmask (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  wsfd_pkg::wsfd_req_t q_data_i,
  output logic                q_rd_o,
  input  logic                pop_i,
  output logic                valid_o,
  output wsfd_pkg::wsfd_res_t res_o
);

  logic                valid_q;
  wsfd_pkg::wsfd_res_t res_q, res_d;

  assign q_rd_o = !q_empty_i && (!valid_q || pop_i);

  always_comb begin
    res_d.data   = q_data_i.raw ^ q_data_i.key;
    res_d.opcode = q_data_i.opcode;
    res_d.kind   = q_data_i.kind;
    res_d.err    = q_data_i.err;
    res_d.len    = q_data_i.len;
    res_d.last   = q_data_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: design/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Client-to-server frame deframer: header checks, mask removal, one result
// per payload byte, a completion for empty frames, an error on bad headers.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  input     | push / full        | in_byte_i, restart_i
//  result    | empty / pop        | data_o, opcode_o, kind_o, error_code_o,
//            |                    | payload_length_o, last_o
//  config    | max_payload_we_i   | max_payload_i
//
//  One byte is accepted per cycle while full is low; the result it causes is
//  written to the request queue, then to the output register.
//  Sustained rate is one byte per cycle, set by the parser, while results are popped.
//  full depends only on the queue fill, so pop never reaches full combinationally.
//  Reset clears parser, queue and output valid; the cap returns to 4096.
//  A stalled consumer backs up the queue, then full rises and input holds.
//
module websocket_frame_deframer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input requests
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        restart_i,
  // results
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  data_o,
  output logic [3:0]  opcode_o,
  output logic [1:0]  kind_o,
  output logic [3:0]  error_code_o,
  output logic [15:0] payload_length_o,
  output logic        last_o,
  // configuration
  input  logic        max_payload_we_i,
  input  logic [15:0] max_payload_i
);

  logic [15:0] max_payload_q;

  logic                accept;
  logic                req_valid;
  wsfd_pkg::wsfd_req_t req;
  wsfd_pkg::wsfd_req_t q_data;
  logic                q_full, q_empty, q_rd;
  logic                res_valid;
  wsfd_pkg::wsfd_res_t res;

  // payload cap register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= wsfd_pkg::CAP_RESET;
    end else if (max_payload_we_i) begin
      max_payload_q <= max_payload_i;
    end
  end

  // A byte is taken only while the queue has room for whatever it produces.
  assign full   = q_full;
  assign accept = push && !q_full;

  wsfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .restart_i     (restart_i),
    .max_payload_i (max_payload_q),
    .req_valid_o   (req_valid),
    .req_o         (req)
  );

  wsfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (req_valid),
    .wdata_i (req),
    .rd_i    (q_rd),
    .rdata_o (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  wsfd_unmask u_unmask (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .valid_o   (res_valid),
    .res_o     (res)
  );

  assign empty            = !res_valid;
  assign data_o           = res.data;
  assign opcode_o         = res.opcode;
  assign kind_o           = res.kind;
  assign error_code_o     = res.err;
  assign payload_length_o = res.len;
  assign last_o           = res.last;

endmodule

// File: design/wsfd_checker.sv
// ----------------------------------------------------------------------------
// wsfd_checker
// Port-level checks on the result channel of the deframer, bound to the
// top level.
// ----------------------------------------------------------------------------
module wsfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  data_o,
  input logic [3:0]  opcode_o,
  input logic [1:0]  kind_o,
  input logic [3:0]  error_code_o,
  input logic [15:0] payload_length_o,
  input logic        last_o
);

  // error results carry only the code
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == wsfd_pkg::KIND_ERROR) |->
      (last_o && data_o == 8'd0 && opcode_o == 4'd0 && payload_length_o == 16'd0 &&
       error_code_o != wsfd_pkg::ERR_NONE))
    else $error("malformed error result");

  // completion of an empty frame
  a_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == wsfd_pkg::KIND_DONE) |->
      (last_o && data_o == 8'd0 && payload_length_o == 16'd0 &&
       error_code_o == wsfd_pkg::ERR_NONE))
    else $error("malformed completion result");

  // payload bytes belong to a nonempty frame and carry no error
  a_data_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == wsfd_pkg::KIND_DATA) |->
      (error_code_o == wsfd_pkg::ERR_NONE && payload_length_o != 16'd0))
    else $error("malformed payload result");

  // a held result does not change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=>
      (!empty && $stable(data_o) && $stable(kind_o) && $stable(last_o)))
    else $error("result changed while stalled");

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (.*);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame deframer. A cycle-level parser model
// predicts every result from the accepted input bytes; a checker compares
// each popped result field by field. Directed header and frame tests run
// first, then randomized frame traffic under several payload caps, with
// bursty input, a patterned receiver stall and a forced back-pressure case.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_STEADY = 2'd0,
    RX_COIN   = 2'd1,
    RX_BEAT   = 2'd2
  } rx_mode_e;

  localparam int DRAIN_LIMIT = 20000;  // cycles allowed for results to come out
  localparam int TAIL_CYCLES = 4;      // settle time for queue and output register, plus margin

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = 8'h00;
  logic        restart = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  data;
  logic [3:0]  opcode;
  logic [1:0]  kind;
  logic [3:0]  error_code;
  logic [15:0] payload_length;
  logic        last;
  logic        cap_we = 1'b0;
  logic [15:0] cap_val = 16'd0;

  websocket_frame_deframer_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push             (push),
    .full             (full),
    .in_byte_i        (in_byte),
    .restart_i        (restart),
    .empty            (empty),
    .pop              (pop),
    .data_o           (data),
    .opcode_o         (opcode),
    .kind_o           (kind),
    .error_code_o     (error_code),
    .payload_length_o (payload_length),
    .last_o           (last),
    .max_payload_we_i (cap_we),
    .max_payload_i    (cap_val)
  );

  // 10 ns clock: rises at 5, falls at 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model state
  // --------------------------------------------------------------------------
  wsfd_pkg::wsfd_phase_e prs_phase;
  logic [3:0]  frm_op;     // opcode, or continuation when FIN was clear
  logic [15:0] frm_len;
  logic [15:0] pay_idx;
  logic [31:0] mask_word;  // key byte k in bits 8k+7..8k
  logic [1:0]  hdr_cnt;    // ext-length / mask byte counter
  logic [15:0] cap_limit;

  wsfd_pkg::wsfd_res_t predicted_out[$];

  // bookkeeping
  int mismatches = 0;
  int checked = 0;
  int seen_data = 0;
  int seen_done = 0;
  int seen_err = 0;
  int bytes_pushed = 0;
  int cap_writes = 0;

  // sender burst control
  int burst_left = 0;
  bit gaps_on = 1'b1;

  // receiver hold-off requests; the receiver process owns the countdown
  int hold_len = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int rx_tick = 0;
  rx_mode_e rx_mode = RX_STEADY;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t MISMATCH %s", $realtime, msg);
  endtask

  task automatic queue_result(input logic [7:0] d, input logic [3:0] op,
                              input wsfd_pkg::wsfd_kind_e k, input wsfd_pkg::wsfd_err_e e,
                              input logic [15:0] len, input logic lst);
    wsfd_pkg::wsfd_res_t r;
    r.data   = d;
    r.opcode = op;
    r.kind   = k;
    r.err    = e;
    r.len    = len;
    r.last   = lst;
    predicted_out.push_back(r);
  endtask

  // a failed check parks the parser until the next restart
  task automatic flag_error(input wsfd_pkg::wsfd_err_e code);
    prs_phase = wsfd_pkg::PH_DROP;
    queue_result(8'h00, wsfd_pkg::OP_CONT, wsfd_pkg::KIND_ERROR, code, 16'd0, 1'b1);
  endtask

  // One accepted byte through the parser model.
  task automatic deframe_step(input logic [7:0] b, input logic rs);
    logic [6:0]  l7;
    logic [7:0]  key_byte;
    logic        fin;
    if (rs) prs_phase = wsfd_pkg::PH_HDR0;
    l7 = b[6:0];
    case (prs_phase)
      wsfd_pkg::PH_HDR0: begin
        // reserved bits are caught on the first byte alone
        if ((b & wsfd_pkg::RSV_MASK) != 8'h00) flag_error(wsfd_pkg::ERR_RSV);
        else begin
          frm_op    = b[7] ? b[3:0] : wsfd_pkg::OP_CONT;
          frm_len   = 16'd0;
          pay_idx   = 16'd0;
          mask_word = 32'd0;
          hdr_cnt   = 2'd0;
          prs_phase = wsfd_pkg::PH_HDR1;
        end
      end
      wsfd_pkg::PH_HDR1: begin
        // mask bit is checked before FIN / continuation
        if (!b[7]) flag_error(wsfd_pkg::ERR_UNMASKED);
        else if (frm_op == wsfd_pkg::OP_CONT) flag_error(wsfd_pkg::ERR_FRAG);
        else if (frm_op != wsfd_pkg::OP_TEXT && frm_op != wsfd_pkg::OP_CLOSE &&
                 frm_op != wsfd_pkg::OP_PING && frm_op != wsfd_pkg::OP_PONG)
          flag_error(wsfd_pkg::ERR_OPCODE);
        else if (frm_op[3] && l7 > wsfd_pkg::LEN_CTRL_MAX) flag_error(wsfd_pkg::ERR_CTRL_LEN);
        else if (l7 == wsfd_pkg::LEN_EXT64) flag_error(wsfd_pkg::ERR_LEN64);
        else begin
          hdr_cnt = 2'd0;
          if (l7 == wsfd_pkg::LEN_EXT16) prs_phase = wsfd_pkg::PH_EXT;
          else if ({9'd0, l7} > cap_limit) flag_error(wsfd_pkg::ERR_CAP);
          else begin
            frm_len   = {9'd0, l7};
            prs_phase = wsfd_pkg::PH_MASK;
          end
        end
      end
      wsfd_pkg::PH_EXT: begin
        frm_len = {frm_len[7:0], b};
        if (hdr_cnt == 2'd0) hdr_cnt = 2'd1;
        else begin
          hdr_cnt = 2'd0;
          if (frm_len < wsfd_pkg::LEN_MIN16) flag_error(wsfd_pkg::ERR_NONMIN);
          else if (frm_len > cap_limit) flag_error(wsfd_pkg::ERR_CAP);
          else prs_phase = wsfd_pkg::PH_MASK;
        end
      end
      wsfd_pkg::PH_MASK: begin
        mask_word = mask_word | ({24'd0, b} << {hdr_cnt, 3'b000});
        if (hdr_cnt != 2'd3) hdr_cnt = hdr_cnt + 2'd1;
        else begin
          hdr_cnt = 2'd0;
          pay_idx = 16'd0;
          // empty payload completes right after the last mask byte
          if (frm_len == 16'd0) begin
            prs_phase = wsfd_pkg::PH_HDR0;
            queue_result(8'h00, frm_op, wsfd_pkg::KIND_DONE, wsfd_pkg::ERR_NONE, 16'd0, 1'b1);
          end else prs_phase = wsfd_pkg::PH_DATA;
        end
      end
      wsfd_pkg::PH_DATA: begin
        key_byte = 8'(mask_word >> {pay_idx[1:0], 3'b000});
        fin = (({1'b0, pay_idx} + 17'd1) >= {1'b0, frm_len});
        queue_result(b ^ key_byte, frm_op, wsfd_pkg::KIND_DATA, wsfd_pkg::ERR_NONE,
                     frm_len, fin);
        pay_idx = pay_idx + 16'd1;
        if (fin) prs_phase = wsfd_pkg::PH_HDR0;
      end
      default: ;  // dropping until restart
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Checker: compare at the rising edge where a result is popped, then feed
  // the model with the byte accepted at the same edge.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h (result %0d)", name, got, want, checked));
  endtask

  always @(posedge clk) begin : result_check
    wsfd_pkg::wsfd_res_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (predicted_out.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d data=%0h", kind, data));
        end else begin
          want = predicted_out.pop_front();
          checked++;
          case (want.kind)
            wsfd_pkg::KIND_DATA: seen_data++;
            wsfd_pkg::KIND_DONE: seen_done++;
            default:             seen_err++;
          endcase
          check_field("data", {8'd0, data}, {8'd0, want.data});
          check_field("opcode", {12'd0, opcode}, {12'd0, want.opcode});
          check_field("kind", {14'd0, kind}, {14'd0, want.kind});
          check_field("error_code", {12'd0, error_code}, {12'd0, want.err});
          check_field("payload_length", payload_length, want.len);
          check_field("last", {15'd0, last}, {15'd0, want.last});
        end
      end
      if (push && !full) deframe_step(in_byte, restart);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: drives pop at the falling edge. Cycles through its own stall
  // patterns; a hold-off request blocks it until the hold_len countdown runs out.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_tick++;
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop = 1'b0;
    end else begin
      if (rx_tick % 97 == 0) rx_mode = rx_mode_e'($urandom_range(0, 2));
      case (rx_mode)
        RX_STEADY: pop = 1'b1;
        RX_COIN:   pop = 1'($urandom_range(0, 1));
        default:   pop = (rx_tick % 5) >= 2;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender side. All tasks start and end at a falling edge.
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic rs);
    int gap;
    if (burst_left == 0) begin
      // a quarter of the bursts run straight on without a gap
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gaps_on && gap > 0) begin
        push = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push    = 1'b1;
    in_byte = b;
    restart = rs;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    bytes_pushed++;
    @(negedge clk);
  endtask

  // Sender pause: wait until every predicted result is out, then let the
  // pipeline settle for bytes that produce nothing.
  task automatic wait_drain();
    int waited;
    waited = 0;
    push = 1'b0;
    while (predicted_out.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (predicted_out.size() != 0) begin
      report_mismatch($sformatf("%0d results never came out", predicted_out.size()));
      predicted_out.delete();
    end
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic set_cap(input logic [15:0] v);
    wait_drain();
    cap_we  = 1'b1;
    cap_val = v;
    @(posedge clk);
    cap_limit = v;
    cap_writes++;
    @(negedge clk);
    cap_we = 1'b0;
  endtask

  // One frame: header, optional extended length, mask key, npay payload bytes.
  // The first byte restarts the parser when the model says it is mid-frame or
  // dropping (most of the time), and now and then for no reason.
  task automatic send_frame(input logic [7:0] hdr0, input logic mbit, input logic [6:0] l7,
                            input logic [15:0] ext16, input int npay);
    logic first_rs;
    first_rs = ((prs_phase != wsfd_pkg::PH_HDR0) && ($urandom_range(0, 9) != 0)) ||
               ($urandom_range(0, 4) == 0);
    push_byte(hdr0, first_rs);
    push_byte({mbit, l7}, 1'b0);
    if (l7 == wsfd_pkg::LEN_EXT16) begin
      push_byte(ext16[15:8], 1'b0);
      push_byte(ext16[7:0], 1'b0);
    end else if (l7 == wsfd_pkg::LEN_EXT64) begin
      repeat (8) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    repeat (4) push_byte(8'($urandom_range(0, 255)), 1'b0);
    repeat (npay) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  function automatic int pick_short_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 8);
    if (r < 80) return $urandom_range(9, 40);
    return $urandom_range(41, 125);
  endfunction

  function automatic logic [3:0] pick_ctrl_op();
    case ($urandom_range(0, 2))
      0:       return wsfd_pkg::OP_CLOSE;
      1:       return wsfd_pkg::OP_PING;
      default: return wsfd_pkg::OP_PONG;
    endcase
  endfunction

  task automatic send_good_frame();
    logic [3:0]  op;
    logic [15:0] plen;
    op = ($urandom_range(0, 1) == 0) ? wsfd_pkg::OP_TEXT : pick_ctrl_op();
    if (op == wsfd_pkg::OP_TEXT && $urandom_range(0, 9) == 0) begin
      plen = 16'($urandom_range(126, 170));
      send_frame({4'h8, op}, 1'b1, wsfd_pkg::LEN_EXT16, plen, int'(plen));
    end else begin
      plen = 16'(pick_short_len());
      send_frame({4'h8, op}, 1'b1, plen[6:0], 16'd0, int'(plen));
    end
  endtask

  // Header faults of every kind, plus ext16 lengths drawn over the full range
  // (accepted long ones are cut short and restarted by the next frame).
  task automatic send_bad_header();
    logic [3:0]  op;
    logic [2:0]  rsv;
    logic [15:0] ext;
    int          r;
    case ($urandom_range(0, 8))
      0: send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)),
                    $urandom_range(0, 6));
      1: send_frame({4'h8, wsfd_pkg::OP_TEXT}, 1'b0, 7'($urandom_range(0, 125)), 16'd0,
                    $urandom_range(0, 4));
      2: send_frame({4'h0, 4'($urandom_range(0, 15))}, 1'b1, 7'($urandom_range(0, 20)),
                    16'd0, $urandom_range(0, 4));
      3: begin
        r = $urandom_range(0, 10);
        op = 4'((r < 6) ? r + 2 : r + 5);
        send_frame({4'h8, op}, 1'b1, 7'($urandom_range(0, 20)), 16'd0,
                   $urandom_range(0, 4));
      end
      4: send_frame({4'h8, pick_ctrl_op()}, 1'b1, 7'($urandom_range(126, 127)),
                    16'd300, $urandom_range(0, 4));
      5: send_frame({4'h8, wsfd_pkg::OP_TEXT}, 1'b1, wsfd_pkg::LEN_EXT64, 16'd0,
                    $urandom_range(0, 4));
      6: begin
        ext = 16'($urandom_range(0, 125));
        send_frame({4'h8, wsfd_pkg::OP_TEXT}, 1'b1, wsfd_pkg::LEN_EXT16, ext,
                   $urandom_range(0, 4));
      end
      7: begin
        ext = 16'($urandom_range(0, 65535));
        send_frame({4'h8, wsfd_pkg::OP_TEXT}, 1'b1, wsfd_pkg::LEN_EXT16, ext,
                   $urandom_range(0, 10));
      end
      default: begin
        rsv = 3'($urandom_range(1, 7));
        send_frame({1'b1, rsv, wsfd_pkg::OP_TEXT}, 1'b1, 7'($urandom_range(0, 20)), 16'd0,
                   $urandom_range(0, 4));
      end
    endcase
  endtask

  // Frame abandoned partway through its payload.
  task automatic send_cut_frame();
    logic [6:0] plen;
    plen = 7'($urandom_range(2, 40));
    send_frame({4'h8, wsfd_pkg::OP_TEXT}, 1'b1, plen, 16'd0, $urandom_range(0, plen - 1));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) < 3);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // every header rejection but the cap check once, in check order, each after a restart
  task automatic test_header_checks();
    push_byte(8'hF1, 1'b1);                            // reserved bits
    push_byte(8'h81, 1'b1); push_byte(8'h05, 1'b0);    // unmasked
    push_byte(8'h01, 1'b1); push_byte(8'h85, 1'b0);    // FIN clear
    push_byte(8'h83, 1'b1); push_byte(8'h80, 1'b0);    // bad opcode
    push_byte(8'h89, 1'b1); push_byte(8'hFE, 1'b0);    // long ping
    push_byte(8'h81, 1'b0);                            // dropped, no restart
    push_byte(8'h81, 1'b1); push_byte(8'hFF, 1'b0);    // 64-bit length
    push_byte(8'h81, 1'b1); push_byte(8'hFE, 1'b0);    // non-minimal 16-bit
    push_byte(8'h00, 1'b0); push_byte(8'h7D, 1'b0);
  endtask

  // empty text frame, then a one-byte pong with an all-ones key
  task automatic test_short_frames();
    push_byte(8'h81, 1'b1); push_byte(8'h80, 1'b0);
    repeat (4) push_byte(8'h00, 1'b0);
    push_byte(8'h8A, 1'b0); push_byte(8'h81, 1'b0);
    repeat (4) push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
  endtask

  // zero cap rejects any payload but passes an empty close;
  // full cap takes a 65535-byte length, cut short after two bytes
  task automatic test_cap_extremes();
    set_cap(16'd0);
    push_byte(8'h81, 1'b1); push_byte(8'h81, 1'b0);
    push_byte(8'h88, 1'b1); push_byte(8'h80, 1'b0);
    repeat (4) push_byte(8'($urandom_range(0, 255)), 1'b0);
    set_cap(16'hFFFF);
    push_byte(8'h81, 1'b1); push_byte(8'hFE, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    repeat (6) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // receiver held off while a long frame streams in: the queue fills and
  // full must hold the sender until the receiver resumes
  task automatic test_backpressure();
    set_cap(wsfd_pkg::CAP_RESET);
    hold_len = 300;
    hold_asked++;
    gaps_on = 1'b0;
    send_frame({4'h8, wsfd_pkg::OP_TEXT}, 1'b1, 7'd60, 16'd0, 60);
    gaps_on = 1'b1;
    wait_drain();
  endtask

  task automatic test_random_traffic(input logic [15:0] cap, input int nbytes);
    int start;
    int pick;
    set_cap(cap);
    start = bytes_pushed;
    while (bytes_pushed - start < nbytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) send_good_frame();
      else if (pick < 86) send_bad_header();
      else if (pick < 93) send_cut_frame();
      else send_noise();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    // model starts from the reset state
    prs_phase = wsfd_pkg::PH_HDR0;
    frm_op    = wsfd_pkg::OP_CONT;
    frm_len   = 16'd0;
    pay_idx   = 16'd0;
    mask_word = 32'd0;
    hdr_cnt   = 2'd0;
    cap_limit = wsfd_pkg::CAP_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_header_checks();
    test_short_frames();
    test_cap_extremes();
    test_backpressure();

    test_random_traffic(wsfd_pkg::CAP_RESET, 190);
    test_random_traffic(16'd0, 190);
    test_random_traffic(16'hFFFF, 190);
    test_random_traffic(16'd125, 190);
    test_random_traffic(16'd126, 190);
    test_random_traffic(16'($urandom_range(0, 65535)), 190);
    test_random_traffic(16'($urandom_range(0, 300)), 190);

    wait_drain();

    $display("summary: %0d bytes in, %0d results checked (%0d payload, %0d empty, %0d errors)",
             bytes_pushed, checked, seen_data, seen_done, seen_err);
    $display("summary: %0d cap writes, %0d mismatches", cap_writes, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("watchdog expired, %0d results still pending", predicted_out.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
